// ----- src/cca_pkg.sv -----
// ----------------------------------------------------------------------------
// cca_pkg
// Shared types and constants of the cluster chain allocator.
// ----------------------------------------------------------------------------
package cca_pkg;

  localparam int LINK_W  = 16;
  localparam int COUNT_W = 13;

  // Lowest cluster number that can hold data.
  localparam logic [LINK_W-1:0] FIRST_CLUSTER = 16'd2;

  localparam logic [COUNT_W-1:0] TABLE_ENTRIES_RST = 13'd4096;
  localparam logic [LINK_W-1:0]  END_MARK_RST      = 16'd65528;

  // Configuration register indexes.
  localparam logic REG_TABLE_ENTRIES = 1'b0;
  localparam logic REG_END_MARK      = 1'b1;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_SET   = 2'd1,
    REQ_ALLOC = 2'd2,
    REQ_FREE  = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_NOSPACE = 2'd2,
    STAT_CAP     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_SCAN,
    S_ALLOC_END,
    S_FREE_CHK,
    S_FREE_WR,
    S_RESP
  } state_t;

  typedef struct packed {
    req_type_t          req_type;
    logic [LINK_W-1:0]  cluster_num;
    logic [LINK_W-1:0]  link_value;
    logic [COUNT_W-1:0] alloc_count;
  } request_t;

  typedef struct packed {
    logic [LINK_W-1:0] result_cluster;
    status_t           status;
  } response_t;

  typedef struct packed {
    logic clearing;
    logic push;
  } eng_stat_t;

endpackage

// ----- src/cca_table_ram.sv -----
// ----------------------------------------------------------------------------
// cca_table_ram
// Allocation table storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cca_table_ram
  import cca_pkg::*;
#(
  parameter int MAX_CLUSTERS = 4096
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [$clog2(MAX_CLUSTERS)-1:0] waddr,
  input  logic [LINK_W-1:0]               wdata,
  input  logic [$clog2(MAX_CLUSTERS)-1:0] raddr,
  output logic [LINK_W-1:0]               rdata
);

  logic [LINK_W-1:0] mem [MAX_CLUSTERS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- src/cca_engine.sv -----
// ----------------------------------------------------------------------------
// cca_engine
// Request sequencer: clearing sweep, read/set, first-fit allocate scan and
// chain free walk, all through the table memory.
// ----------------------------------------------------------------------------
module cca_engine
  import cca_pkg::*;
#(
  parameter int MAX_CLUSTERS = 4096,
  localparam int AW   = $clog2(MAX_CLUSTERS),
  localparam int CMPW = (AW + 1 > LINK_W) ? AW + 1 : LINK_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  request_t          req,
  input  logic [CMPW-1:0]   n_used,
  input  logic [LINK_W-1:0] end_mark,
  input  logic              out_free,
  output response_t         resp,
  output eng_stat_t         stat,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output logic [LINK_W-1:0] mem_wdata,
  output logic [AW-1:0]     mem_raddr,
  input  logic [LINK_W-1:0] mem_rdata
);

  function automatic logic is_valid(input logic [LINK_W-1:0] c,
                                    input logic [LINK_W-1:0] em,
                                    input logic [CMPW-1:0]   nn);
    return (c >= FIRST_CLUSTER) && (c < em) && (CMPW'(c) < nn);
  endfunction

  state_t             state, state_next;
  logic [AW-1:0]      clr_addr, clr_addr_next;
  logic [CMPW-1:0]    scan_c, scan_c_next;
  logic               chk_v, chk_v_next;
  logic [CMPW-1:0]    chk_c, chk_c_next;
  logic [COUNT_W-1:0] cnt, cnt_next;
  logic               have, have_next;
  logic [LINK_W-1:0]  first, first_next;
  logic [LINK_W-1:0]  prev, prev_next;
  logic [LINK_W-1:0]  cur, cur_next;
  logic [CMPW-1:0]    steps, steps_next;
  logic               from_alloc, from_alloc_next;
  logic [LINK_W-1:0]  res, res_next;
  status_t            st, st_next;

  logic in_valid_req, scan_issue, scan_hit, cur_ok, cap_hit;

  assign in_valid_req = is_valid(req.cluster_num, end_mark, n_used);
  assign scan_issue   = scan_c < n_used;
  assign scan_hit     = chk_v && (mem_rdata == '0) && (chk_c < CMPW'(end_mark));
  assign cur_ok       = is_valid(cur, end_mark, n_used);
  assign cap_hit      = steps >= n_used;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == AW'(MAX_CLUSTERS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          unique case (req.req_type)
            REQ_READ:  state_next = in_valid_req ? S_READ : S_RESP;
            REQ_SET:   state_next = S_RESP;
            REQ_ALLOC: state_next = (req.alloc_count == '0) ? S_RESP : S_SCAN;
            REQ_FREE:  state_next = in_valid_req ? S_FREE_CHK : S_RESP;
          endcase
        end
      end
      S_READ:      state_next = S_RESP;
      S_SCAN: begin
        if (scan_hit && cnt == COUNT_W'(1)) begin
          state_next = S_ALLOC_END;
        end else if (!chk_v && !scan_issue) begin
          state_next = have ? S_FREE_CHK : S_RESP;
        end
      end
      S_ALLOC_END: state_next = S_RESP;
      S_FREE_CHK:  state_next = (cur_ok && !cap_hit) ? S_FREE_WR : S_RESP;
      S_FREE_WR:   state_next = S_FREE_CHK;
      S_RESP: begin
        if (out_free) state_next = S_IDLE;
      end
      default:     state_next = S_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    in_ready        = 1'b0;
    stat.clearing   = 1'b0;
    stat.push       = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = clr_addr;
    mem_wdata       = '0;
    mem_raddr       = cur[AW-1:0];
    clr_addr_next   = clr_addr;
    scan_c_next     = scan_c;
    chk_v_next      = 1'b0;
    chk_c_next      = chk_c;
    cnt_next        = cnt;
    have_next       = have;
    first_next      = first;
    prev_next       = prev;
    cur_next        = cur;
    steps_next      = steps;
    from_alloc_next = from_alloc;
    res_next        = res;
    st_next         = st;
    unique case (state)
      S_CLEAR: begin
        stat.clearing = 1'b1;
        mem_we        = 1'b1;
        clr_addr_next = clr_addr + AW'(1);
      end
      S_IDLE: begin
        in_ready  = 1'b1;
        mem_raddr = req.cluster_num[AW-1:0];
        res_next  = end_mark;
        st_next   = STAT_OK;
        if (in_valid) begin
          unique case (req.req_type)
            REQ_READ: begin
              if (!in_valid_req) st_next = STAT_INVALID;
            end
            REQ_SET: begin
              if (in_valid_req) begin
                mem_we    = 1'b1;
                mem_waddr = req.cluster_num[AW-1:0];
                mem_wdata = req.link_value;
                res_next  = '0;
              end else begin
                st_next = STAT_INVALID;
              end
            end
            REQ_ALLOC: begin
              cnt_next        = req.alloc_count;
              scan_c_next     = CMPW'(FIRST_CLUSTER);
              have_next       = 1'b0;
              from_alloc_next = 1'b1;
              if (req.alloc_count == '0) st_next = STAT_NOSPACE;
            end
            REQ_FREE: begin
              cur_next        = req.cluster_num;
              steps_next      = '0;
              from_alloc_next = 1'b0;
              if (!in_valid_req) st_next = STAT_INVALID;
            end
          endcase
        end
      end
      S_READ: begin
        res_next = mem_rdata;
      end
      S_SCAN: begin
        // Reads run one entry ahead of the free check; links always land
        // below the entry being checked, so no forwarding is needed.
        mem_raddr = scan_c[AW-1:0];
        if (scan_issue) begin
          chk_v_next  = 1'b1;
          chk_c_next  = scan_c;
          scan_c_next = scan_c + CMPW'(1);
        end
        if (scan_hit) begin
          if (have) begin
            mem_we    = 1'b1;
            mem_waddr = prev[AW-1:0];
            mem_wdata = chk_c[LINK_W-1:0];
          end else begin
            first_next = chk_c[LINK_W-1:0];
          end
          have_next = 1'b1;
          prev_next = chk_c[LINK_W-1:0];
          cnt_next  = cnt - COUNT_W'(1);
        end
        if (!chk_v && !scan_issue) begin
          // Ran out of space: give back the partial chain if there is one.
          st_next    = STAT_NOSPACE;
          cur_next   = first;
          steps_next = '0;
        end
      end
      S_ALLOC_END: begin
        mem_we    = 1'b1;
        mem_waddr = prev[AW-1:0];
        mem_wdata = end_mark;
        res_next  = first;
        st_next   = STAT_OK;
      end
      S_FREE_CHK: begin
        mem_raddr = cur[AW-1:0];
        if (!cur_ok) begin
          res_next = from_alloc ? end_mark : '0;
          st_next  = from_alloc ? STAT_NOSPACE : STAT_OK;
        end else if (cap_hit) begin
          res_next = end_mark;
          st_next  = from_alloc ? STAT_NOSPACE : STAT_CAP;
        end
      end
      S_FREE_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = cur[AW-1:0];
        cur_next   = mem_rdata;
        steps_next = steps + CMPW'(1);
      end
      S_RESP: begin
        stat.push = out_free;
      end
      default: begin
      end
    endcase
  end

  assign resp.result_cluster = res;
  assign resp.status         = st;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      chk_v    <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      chk_v    <= chk_v_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_c     <= scan_c_next;
    chk_c      <= chk_c_next;
    cnt        <= cnt_next;
    have       <= have_next;
    first      <= first_next;
    prev       <= prev_next;
    cur        <= cur_next;
    steps      <= steps_next;
    from_alloc <= from_alloc_next;
    res        <= res_next;
    st         <= st_next;
  end

endmodule

// ----- src/cluster_chain_allocator_top.sv -----
// ----------------------------------------------------------------------------
// cluster_chain_allocator_top
// FAT16 cluster chain allocator with the allocation table in on-chip memory.
// ----------------------------------------------------------------------------
// A read looks up one table entry and a set writes one; an allocate scans the table first
// fit (a failed one adds the walk over its partial chain), and a free walks the chain
// entry by entry. One request is in work at a time; the output register takes the result
// so the next beat can be accepted meanwhile.
// After reset the table is cleared by a sweep over all MAX_CLUSTERS entries during which no input
// beat is accepted; configuration writes are taken at once.
module cluster_chain_allocator_top
  import cca_pkg::*;
#(
  parameter int MAX_CLUSTERS = 4096
) (
  input  logic               clk,
  input  logic               rst,
  // Configuration write port.
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [LINK_W-1:0]  cfg_data,
  // Request stream.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // [15:0] cluster_num, [31:16] link_value, [44:32] alloc_count, rest zero
  input  logic [47:0]        s_axis_tdata,
  // [1:0] req_type
  input  logic [1:0]         s_axis_tuser,
  // Result stream.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [15:0] result_cluster
  output logic [15:0]        m_axis_tdata,
  // [1:0] status
  output logic [1:0]         m_axis_tuser
);

  localparam int AW   = $clog2(MAX_CLUSTERS);
  localparam int CMPW = (AW + 1 > LINK_W) ? AW + 1 : LINK_W;

  // Configuration registers.
  logic [COUNT_W-1:0] table_entries;
  logic [LINK_W-1:0]  end_mark;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_entries <= TABLE_ENTRIES_RST;
      end_mark      <= END_MARK_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_TABLE_ENTRIES: table_entries <= cfg_data[COUNT_W-1:0];
        REG_END_MARK:      end_mark      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Entries in use, saturated to the size of the memory.
  logic [CMPW-1:0] te_ext;
  logic [CMPW-1:0] n_used;

  assign te_ext = CMPW'(table_entries);
  assign n_used = (te_ext > CMPW'(MAX_CLUSTERS)) ? CMPW'(MAX_CLUSTERS) : te_ext;

  // Unpack the request beat.
  request_t req;

  assign req.req_type    = req_type_t'(s_axis_tuser);
  assign req.cluster_num = s_axis_tdata[15:0];
  assign req.link_value  = s_axis_tdata[31:16];
  assign req.alloc_count = s_axis_tdata[44:32];

  // Output register: holds one finished result until the sink takes it.
  response_t         resp;
  eng_stat_t         stat;
  logic              out_free;
  logic              out_valid;
  logic [LINK_W-1:0] out_cluster;
  status_t           out_status;

  assign out_free = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stat.push) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.push) begin
      out_cluster <= resp.result_cluster;
      out_status  <= resp.status;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_cluster;
  assign m_axis_tuser  = out_status;

  // Table memory and the sequencer that drives it.
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [LINK_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [LINK_W-1:0] mem_rdata;

  cca_engine #(
    .MAX_CLUSTERS(MAX_CLUSTERS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .req      (req),
    .n_used   (n_used),
    .end_mark (end_mark),
    .out_free (out_free),
    .resp     (resp),
    .stat     (stat),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  cca_table_ram #(
    .MAX_CLUSTERS(MAX_CLUSTERS)
  ) u_table (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // The sequencer only hands over a result when the output register can
  // take it, so no result is ever overwritten.
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    stat.push |-> out_free)
    else $error("result pushed into a full output register");

  // A request is never taken while a result is being handed over.
  a_no_accept_on_push: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tvalid && s_axis_tready && stat.push))
    else $error("request accepted while a result is pushed");

  // Outside the clearing sweep, every table write lands inside the table.
  a_write_in_table: assert property (@(posedge clk) disable iff (rst)
    (mem_we && !stat.clearing) |-> (CMPW'(mem_waddr) < n_used))
    else $error("table write outside the entries in use");

endmodule

// ----- dv/cluster_chain_allocator_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cluster_chain_allocator_top_test
// Self-checking bench for the FAT16 cluster chain allocator.
// A shadow copy of the allocation table predicts the reply to each accepted
// request. Replies are checked in order against that prediction, over several
// table size and end mark settings, with random stalls on both streams.
// ----------------------------------------------------------------------------
module cluster_chain_allocator_top_test;
  import cca_pkg::*;

  localparam int CLK_PERIOD  = 12;
  localparam int TABLE_DEPTH = 4096;
  // Idle cycles allowed after the last reply before a register write or
  // the end of the run.
  localparam int SETTLE      = 16;

  // Shadow of the allocation table plus the queue of replies still owed.
  class fat_mirror;
    logic [LINK_W-1:0]  links [TABLE_DEPTH];
    logic [COUNT_W-1:0] entries;
    logic [LINK_W-1:0]  end_mark;
    int unsigned        last_alloc;
    int unsigned        mismatches;
    response_t          due_replies [$];

    function new();
      foreach (links[i]) links[i] = '0;
      entries     = TABLE_ENTRIES_RST;
      end_mark    = END_MARK_RST;
      last_alloc  = 0;
      mismatches  = 0;
    endfunction

    function int unsigned span();
      return (entries > TABLE_DEPTH) ? TABLE_DEPTH : entries;
    endfunction

    function bit usable(int unsigned c);
      return c >= FIRST_CLUSTER && c < end_mark && c < span();
    endfunction

    function int unsigned pending();
      return due_replies.size();
    endfunction

    function void set_register(logic idx, logic [LINK_W-1:0] val);
      if (idx == REG_TABLE_ENTRIES) begin
        entries = val[COUNT_W-1:0];
      end else begin
        end_mark = val;
      end
    endfunction

    // Follows a chain and zeroes every entry it passes. Returns 0 when the
    // step cap is reached while the next cluster is still valid.
    function bit clear_chain(int unsigned start);
      int unsigned cur;
      int unsigned nxt;
      int unsigned steps;
      cur   = start;
      steps = 0;
      while (usable(cur)) begin
        if (steps >= span()) return 1'b0;
        nxt       = links[cur];
        links[cur] = '0;
        cur       = nxt;
        steps++;
      end
      return 1'b1;
    endfunction

    function void note_request(request_t r);
      response_t   rsp;
      int unsigned want;
      int unsigned first;
      int unsigned prev;
      bit          found;
      rsp.result_cluster = end_mark;
      rsp.status         = STAT_OK;
      case (r.req_type)
        REQ_READ: begin
          if (usable(r.cluster_num)) rsp.result_cluster = links[r.cluster_num];
          else rsp.status = STAT_INVALID;
        end
        REQ_SET: begin
          if (usable(r.cluster_num)) begin
            links[r.cluster_num] = r.link_value;
            rsp.result_cluster   = '0;
          end else begin
            rsp.status = STAT_INVALID;
          end
        end
        REQ_ALLOC: begin
          want  = r.alloc_count;
          found = 1'b0;
          first = 0;
          prev  = 0;
          // First fit upward; clusters at or above the end mark are skipped.
          for (int unsigned c = FIRST_CLUSTER; c < span() && want != 0; c++) begin
            if (usable(c) && links[c] == '0) begin
              if (found) links[prev] = LINK_W'(c);
              else first = c;
              found = 1'b1;
              prev  = c;
              want--;
            end
          end
          if (found && want == 0) begin
            links[prev]        = end_mark;
            rsp.result_cluster = LINK_W'(first);
            last_alloc         = first;
          end else begin
            // Short of space: the partial chain is given back.
            if (found) void'(clear_chain(first));
            rsp.status = STAT_NOSPACE;
          end
        end
        default: begin
          if (!usable(r.cluster_num)) rsp.status = STAT_INVALID;
          else if (clear_chain(r.cluster_num)) rsp.result_cluster = '0;
          else rsp.status = STAT_CAP;
        end
      endcase
      due_replies.push_back(rsp);
    endfunction

    function void check_reply(logic [LINK_W-1:0] cl, logic [1:0] st);
      response_t want_rsp;
      if (due_replies.size() == 0) begin
        $display("%0t: reply with nothing pending: expected none, actual cluster %0d status %0d",
                 $time, cl, st);
        mismatches++;
        return;
      end
      want_rsp = due_replies.pop_front();
      if (cl !== want_rsp.result_cluster) begin
        $display("%0t: result_cluster mismatch: expected %0d, actual %0d",
                 $time, want_rsp.result_cluster, cl);
        mismatches++;
      end
      if (st !== want_rsp.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, want_rsp.status, st);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic               cfg_addr;
  logic [LINK_W-1:0]  cfg_data;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [47:0]        s_axis_tdata;
  logic [1:0]         s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [15:0]        m_axis_tdata;
  logic [1:0]         m_axis_tuser;

  // Constructed at elaboration so the reply checker never sees a null handle.
  fat_mirror sb = new();

  // When set, the request side sends back to back for the current phase.
  bit steady;

  cluster_chain_allocator_top #(
    .MAX_CLUSTERS(TABLE_DEPTH)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Hard stop. The slowest legal run is bounded by roughly 150 requests, each
  // needing a full table scan plus a full free walk with
  // the worst stalls added; this limit is several times that, and also covers
  // the clearing sweep after reset.
  initial begin
    #(CLK_PERIOD * 8_000_000);
    $display("Verification failed");
    $finish;
  end

  function automatic int unsigned gap_cycles();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic request_t make_request(req_type_t t, int unsigned cl,
                                            int unsigned lk, int unsigned cnt);
    request_t r;
    r.req_type    = t;
    r.cluster_num = LINK_W'(cl);
    r.link_value  = LINK_W'(lk);
    r.alloc_count = COUNT_W'(cnt);
    return r;
  endfunction

  // Random request shaped by the current setting. Most clusters land inside
  // or just past the table, and many requests revisit the last chain
  // handed out, so chains get built, read, relinked and freed.
  function automatic request_t random_request();
    request_t    r;
    int unsigned top;
    int unsigned pick;
    top  = sb.span();
    pick = $urandom_range(0, 99);
    if (pick < 25) r.req_type = REQ_READ;
    else if (pick < 45) r.req_type = REQ_SET;
    else if (pick < 75) r.req_type = REQ_ALLOC;
    else r.req_type = REQ_FREE;

    pick = $urandom_range(0, 99);
    if (pick < 45 && sb.last_alloc != 0) r.cluster_num = LINK_W'(sb.last_alloc);
    else if (pick < 85) r.cluster_num = LINK_W'($urandom_range(0, top + 1));
    else r.cluster_num = LINK_W'($urandom);

    pick = $urandom_range(0, 99);
    if (pick < 35) r.link_value = LINK_W'($urandom_range(FIRST_CLUSTER, top - 1));
    else if (pick < 55) r.link_value = sb.end_mark;
    else if (pick < 65) r.link_value = '0;
    else r.link_value = LINK_W'($urandom);

    pick = $urandom_range(0, 99);
    if (pick < 70) r.alloc_count = COUNT_W'($urandom_range(1, 4));
    else if (pick < 78) r.alloc_count = '0;
    else if (pick < 95) r.alloc_count = COUNT_W'($urandom_range(1, top));
    else r.alloc_count = COUNT_W'($urandom_range(0, TABLE_DEPTH));
    return r;
  endfunction

  // Holds the beat until it is taken, then books the predicted reply.
  // tvalid is left high; the caller lowers it only when a gap follows.
  task automatic send_request(request_t r);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, r.alloc_count, r.link_value, r.cluster_num};
    s_axis_tuser  <= r.req_type;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(r);
  endtask

  task automatic pause_sender();
    int unsigned n;
    n = gap_cycles();
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stops sending until every booked reply has come back. The loop waits on the
  // clock before it checks, so tvalid is never lowered and raised in the same step.
  task automatic drain_replies();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(logic idx, logic [LINK_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sb.set_register(idx, val);
  endtask

  // One setting of the two registers followed by a run of random requests.
  // The block is idle before the writes: every reply is in and the engine
  // has had time to settle.
  task automatic run_phase(int unsigned entries, int unsigned mark, int unsigned count);
    drain_replies();
    repeat (SETTLE) @(posedge clk);
    write_reg(REG_TABLE_ENTRIES, LINK_W'(entries));
    write_reg(REG_END_MARK, LINK_W'(mark));
    steady = ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < count; i++) begin
      send_request(random_request());
      // Now and then hold off until the block has answered everything.
      if ($urandom_range(0, 29) == 0) drain_replies();
      else pause_sender();
    end
  endtask

  // Result side: ready alternates between runs and stalls. Stalls are mostly
  // short with a few long ones, and some ready runs are long enough to give
  // stretches with no back pressure at all.
  initial begin : reply_sink
    int unsigned hold;
    bit          rdy;
    hold          = 0;
    rdy           = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        sb.check_reply(m_axis_tdata, m_axis_tuser);
      end
      if (hold == 0) begin
        rdy = !rdy;
        if (rdy) begin
          hold = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 300)
                                             : $urandom_range(1, 12);
        end else begin
          hold = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                              : $urandom_range(15, 40);
        end
      end
      hold--;
      m_axis_tready <= rdy;
    end
  end

  initial begin : stimulus
    request_t directed [$];
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_addr      = REG_TABLE_ENTRIES;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_READ;
    steady        = 1'b0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset setting (4096 entries, end mark 65528).
    // The first beat waits out the table clearing sweep on tready.
    // Reads at both edges of the valid range and just outside it.
    directed.push_back(make_request(REQ_READ, 2, 0, 0));
    directed.push_back(make_request(REQ_READ, 0, 0, 0));
    directed.push_back(make_request(REQ_READ, 1, 0, 0));
    directed.push_back(make_request(REQ_READ, 4095, 0, 0));
    directed.push_back(make_request(REQ_READ, 4096, 0, 0));
    directed.push_back(make_request(REQ_READ, 16'hFFFF, 0, 0));
    // Set with all link bits high, read it back, then reject invalid sets.
    directed.push_back(make_request(REQ_SET, 2, 16'hFFFF, 0));
    directed.push_back(make_request(REQ_READ, 2, 0, 0));
    directed.push_back(make_request(REQ_SET, 0, 16'h1234, 0));
    directed.push_back(make_request(REQ_SET, 4096, 16'h1234, 0));
    // Free of a single entry whose link is out of range, and invalid frees.
    directed.push_back(make_request(REQ_FREE, 2, 0, 0));
    directed.push_back(make_request(REQ_FREE, 1, 0, 0));
    directed.push_back(make_request(REQ_FREE, 16'hFFFF, 0, 0));
    // Allocate of zero fails; then a few chains with a hole in between.
    directed.push_back(make_request(REQ_ALLOC, 0, 0, 0));
    directed.push_back(make_request(REQ_ALLOC, 0, 0, 3));
    directed.push_back(make_request(REQ_ALLOC, 0, 0, 1));
    directed.push_back(make_request(REQ_READ, 3, 0, 0));
    directed.push_back(make_request(REQ_FREE, 3, 0, 0));
    directed.push_back(make_request(REQ_ALLOC, 0, 0, 4));
    // More than the table holds: the partial chain must be released.
    directed.push_back(make_request(REQ_ALLOC, 0, 0, TABLE_DEPTH));
    directed.push_back(make_request(REQ_READ, 100, 0, 0));
    // A chain that loops back on itself must still terminate when freed.
    directed.push_back(make_request(REQ_SET, 4095, 10, 0));
    directed.push_back(make_request(REQ_SET, 10, 4095, 0));
    directed.push_back(make_request(REQ_FREE, 10, 0, 0));
    directed.push_back(make_request(REQ_READ, 4095, 0, 0));
    foreach (directed[i]) begin
      send_request(directed[i]);
      pause_sender();
    end

    // Random part across settings: tiny tables, end marks below the table
    // size so the scan must skip entries, both register extremes, and an
    // oversized table size that saturates to the full depth. Small tables
    // carry most of the requests since an allocate can scan the whole table.
    run_phase(16, 65528, 20);
    run_phase(3, 65535, 10);
    run_phase(40, 20, 20);
    run_phase(64, 3, 10);
    run_phase(8191, 65528, 8);
    run_phase($urandom_range(5, 100), $urandom_range(3, 120), 30);
    run_phase(TABLE_DEPTH, 4000, 10);
    run_phase(24, 65528, 12);

    drain_replies();
    repeat (SETTLE) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/cca_pkg.sv
src/cca_table_ram.sv
src/cca_engine.sv
src/cluster_chain_allocator_top.sv
dv/cluster_chain_allocator_top_test.sv
